// File: hw/rtl/centroid_track_matcher_assert.svh
// Assertion macros shared by the centroid track matcher RTL.
// Depends on nothing; included by ctm_datapath, the module that carries assertions.
`ifndef CENTROID_TRACK_MATCHER_ASSERT_SVH
`define CENTROID_TRACK_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CTM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("centroid track matcher: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("centroid track matcher: next-cycle check failed");

`endif

// File: hw/rtl/ctm_pkg.sv
// Shared types and constants for the centroid track matcher.
// No dependencies; imported by every module of the block.
package ctm_pkg;

   // Parameter defaults.
   localparam int MAX_TRACKS_DEF = 16;
   localparam int COORD_BITS_DEF = 11;

   // Field widths of the beats.
   localparam int POS_W  = 11;
   localparam int DIAG_W = 12;
   localparam int ID_W   = 16;
   localparam int MISS_W = 3;
   localparam int LIVE_W = 5;

   // Miss counter saturation value.
   localparam logic [MISS_W-1:0] MISS_SAT = 3'd7;

   // Configuration registers.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int LINE_ROW_W  = 11;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_ROW   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MISS_LIMIT = 2'd1;
   localparam logic [LINE_ROW_W-1:0]  LINE_ROW_RESET   = 11'd288;
   localparam logic [MISS_W-1:0]      MISS_LIMIT_RESET = 3'd7;

   // Item kinds.
   localparam logic ACT_EOF = 1'b1;

   typedef struct packed {
      logic              action;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [DIAG_W-1:0] diagonal;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]   track_id;
      logic              new_track;
      logic              table_full;
      logic [LIVE_W-1:0] live_tracks;
      logic [LIVE_W-1:0] crossings;
      logic [ID_W-1:0]   total_count;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic issue;
      logic commit_det;
      logic commit_eof;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_eof;
      logic scan_done;
      logic out_free;
   } status_type;

endpackage

// File: hw/rtl/ctm_ctrl.sv
// Controller state machine of the centroid track matcher.
// Depends on ctm_pkg for the command and status structs.
module ctm_ctrl import ctm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Input beats are only taken between items.
   assign req_stall = (state_ff != S_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.issue = 1'b1;
            if (status.scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (status.out_free) begin
               if (status.is_eof) begin
                  cmd.commit_eof = 1'b1;
               end else begin
                  cmd.commit_det = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/ctm_datapath.sv
// Datapath of the centroid track matcher: track table memory, distance
// pipeline, frame sweep, configuration registers and result register.
// Depends on ctm_pkg and centroid_track_matcher_assert.svh.
`include "centroid_track_matcher_assert.svh"
module ctm_datapath import ctm_pkg::*; #(
   parameter int MAX_TRACKS = MAX_TRACKS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int CNT_W = $clog2(MAX_TRACKS + 1);
   localparam int SQ_W  = 2 * COORD_BITS;
   localparam int D2_W  = SQ_W + 1;
   localparam int DG2_W = 2 * DIAG_W;
   localparam int CMP_W = (D2_W > DG2_W) ? D2_W : DG2_W;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] prev_y;
      logic [MISS_W-1:0]     misses;
      logic [ID_W-1:0]       ident;
   } entry_type;

   // Track table and its registered read port.
   entry_type             track_mem_ff [MAX_TRACKS];
   entry_type             rdata_ff;
   logic                  rd_en;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   entry_type             wr_data;

   // Item latch and match radius squared.
   req_type               req_ff;
   logic [DG2_W-1:0]      dg2_ff;
   logic [COORD_BITS-1:0] px, py, lr;
   logic                  is_eof;

   // Scan pipeline.
   logic [CNT_W-1:0]      rd_idx_ff;
   logic                  p1_vld_ff;
   logic [IDX_W-1:0]      p1_idx_ff;
   logic [COORD_BITS-1:0] dx, dy;
   logic [SQ_W-1:0]       dx2_ff, dy2_ff;
   logic                  p2_vld_ff;
   logic [IDX_W-1:0]      p2_idx_ff;
   entry_type             p2_ent_ff;
   logic [D2_W-1:0]       d2;
   logic                  better;
   logic [D2_W-1:0]       best_ff;
   entry_type             best_ent_ff;
   logic [IDX_W-1:0]      best_idx_ff;
   logic                  found_ff;

   // Frame sweep.
   logic [CNT_W-1:0]      k_ff;
   logic [CNT_W-1:0]      crossed_ff;
   logic [MISS_W-1:0]     mis_new;
   logic                  keep;
   logic                  crosses;
   logic                  sweep_wr;

   // Table bookkeeping and running totals.
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [MAX_TRACKS-1:0] matched_ff, matched_in;
   logic [ID_W-1:0]       next_id_ff;
   logic [ID_W-1:0]       total_ff;
   logic                  match;
   logic                  full;

   // Configuration and result.
   logic [LINE_ROW_W-1:0] line_row_ff;
   logic [MISS_W-1:0]     miss_limit_ff;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff;

   assign px     = COORD_BITS'(req_ff.pos_x);
   assign py     = COORD_BITS'(req_ff.pos_y);
   assign lr     = COORD_BITS'(line_row_ff);
   assign is_eof = (req_ff.action == ACT_EOF);
   assign rd_en  = cmd.issue && (rd_idx_ff != n_ff);

   // First pipeline stage: absolute coordinate differences.
   always_comb begin
      dx = (px > rdata_ff.x) ? (px - rdata_ff.x) : (rdata_ff.x - px);
      dy = (py > rdata_ff.y) ? (py - rdata_ff.y) : (rdata_ff.y - py);
   end

   // Second pipeline stage: squared distance against the best so far.
   assign d2     = D2_W'(dx2_ff) + D2_W'(dy2_ff);
   assign better = !found_ff || (d2 < best_ff);

   // Sweep stage: age unmatched tracks, drop expired ones, test the line.
   always_comb begin
      mis_new = rdata_ff.misses;
      if (!matched_ff[p1_idx_ff] && (rdata_ff.misses < MISS_SAT)) begin
         mis_new = rdata_ff.misses + MISS_W'(1);
      end
      keep     = (mis_new != miss_limit_ff);
      crosses  = (rdata_ff.prev_y > lr) && (rdata_ff.y <= lr);
      sweep_wr = p1_vld_ff && is_eof && keep;
   end

   // Detection outcome.
   assign match = found_ff && (CMP_W'(best_ff) < CMP_W'(dg2_ff));
   assign full  = (n_ff == CNT_W'(MAX_TRACKS));

   // Table write port: sweep compaction or detection commit.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = best_idx_ff;
      wr_data = rdata_ff;
      if (sweep_wr) begin
         wr_en          = 1'b1;
         wr_addr        = k_ff[IDX_W-1:0];
         wr_data.misses = mis_new;
      end else if (cmd.commit_det && match) begin
         wr_en          = 1'b1;
         wr_addr        = best_idx_ff;
         wr_data.x      = px;
         wr_data.y      = py;
         wr_data.prev_y = best_ent_ff.y;
         wr_data.misses = best_ent_ff.misses;
         wr_data.ident  = best_ent_ff.ident;
      end else if (cmd.commit_det && !full) begin
         wr_en          = 1'b1;
         wr_addr        = n_ff[IDX_W-1:0];
         wr_data.x      = px;
         wr_data.y      = py;
         wr_data.prev_y = py;
         wr_data.misses = '0;
         wr_data.ident  = next_id_ff;
      end
   end

   // Live count, match flags and the result beat.
   always_comb begin
      n_in       = n_ff;
      matched_in = matched_ff;
      rsp_in     = rsp_ff;
      if (cmd.commit_det) begin
         rsp_in.crossings   = '0;
         rsp_in.total_count = total_ff;
         rsp_in.new_track   = 1'b0;
         rsp_in.table_full  = 1'b0;
         rsp_in.track_id    = '0;
         if (match) begin
            matched_in[best_idx_ff] = 1'b1;
            rsp_in.track_id         = best_ent_ff.ident;
         end else if (!full) begin
            matched_in[n_ff[IDX_W-1:0]] = 1'b1;
            n_in                        = n_ff + CNT_W'(1);
            rsp_in.track_id             = next_id_ff;
            rsp_in.new_track            = 1'b1;
         end else begin
            rsp_in.table_full = 1'b1;
         end
         rsp_in.live_tracks = LIVE_W'(n_in);
      end else if (cmd.commit_eof) begin
         n_in               = k_ff;
         matched_in         = '0;
         rsp_in.track_id    = '0;
         rsp_in.new_track   = 1'b0;
         rsp_in.table_full  = 1'b0;
         rsp_in.live_tracks = LIVE_W'(k_ff);
         rsp_in.crossings   = LIVE_W'(crossed_ff);
         rsp_in.total_count = total_ff + ID_W'(crossed_ff);
      end
   end

   // Track table memory.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         track_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= track_mem_ff[rd_idx_ff[IDX_W-1:0]];
      end
   end

   // Payload registers of the scan.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
      dg2_ff <= DG2_W'(req_ff.diagonal) * DG2_W'(req_ff.diagonal);
      if (rd_en) begin
         p1_idx_ff <= rd_idx_ff[IDX_W-1:0];
      end
      if (p1_vld_ff) begin
         dx2_ff    <= SQ_W'(dx) * SQ_W'(dx);
         dy2_ff    <= SQ_W'(dy) * SQ_W'(dy);
         p2_ent_ff <= rdata_ff;
         p2_idx_ff <= p1_idx_ff;
      end
      if (p2_vld_ff && better) begin
         best_ff     <= d2;
         best_ent_ff <= p2_ent_ff;
         best_idx_ff <= p2_idx_ff;
      end
      if (cmd.commit_det || cmd.commit_eof) begin
         rsp_ff <= rsp_in;
      end
   end

   // Control registers, counters and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff     <= '0;
         p1_vld_ff     <= 1'b0;
         p2_vld_ff     <= 1'b0;
         found_ff      <= 1'b0;
         k_ff          <= '0;
         crossed_ff    <= '0;
         n_ff          <= '0;
         matched_ff    <= '0;
         next_id_ff    <= '0;
         total_ff      <= '0;
         line_row_ff   <= LINE_ROW_RESET;
         miss_limit_ff <= MISS_LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         p1_vld_ff  <= rd_en;
         p2_vld_ff  <= p1_vld_ff && !is_eof;
         n_ff       <= n_in;
         matched_ff <= matched_in;
         if (cmd.load) begin
            rd_idx_ff  <= '0;
            found_ff   <= 1'b0;
            k_ff       <= '0;
            crossed_ff <= '0;
         end else begin
            if (rd_en) begin
               rd_idx_ff <= rd_idx_ff + CNT_W'(1);
            end
            if (p2_vld_ff) begin
               found_ff <= 1'b1;
            end
            if (sweep_wr) begin
               k_ff       <= k_ff + CNT_W'(1);
               crossed_ff <= crossed_ff + CNT_W'(crosses);
            end
         end
         if (cmd.commit_det && !match && !full) begin
            next_id_ff <= next_id_ff + ID_W'(1);
         end
         if (cmd.commit_eof) begin
            total_ff <= rsp_in.total_count;
         end
         if (cmd.commit_det || cmd.commit_eof) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_LINE_ROW:   line_row_ff   <= csr_wdata[LINE_ROW_W-1:0];
               CSR_MISS_LIMIT: miss_limit_ff <= csr_wdata[MISS_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign status.is_eof    = is_eof;
   assign status.scan_done = (rd_idx_ff == n_ff) && !p1_vld_ff && !p2_vld_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload      = rsp_ff;

   // The table never holds more tracks than it has slots.
   `CTM_ASSERT_NOW(a_live_bound, clock, reset, 1'b1, n_ff <= CNT_W'(MAX_TRACKS))
   // Compaction never writes ahead of the entry being read.
   `CTM_ASSERT_NOW(a_sweep_order, clock, reset, sweep_wr, k_ff <= CNT_W'(p1_idx_ff))
   // A commit only happens once the scan pipeline has drained.
   `CTM_ASSERT_NOW(a_commit_drained, clock, reset, cmd.commit_det || cmd.commit_eof,
      !p1_vld_ff && !p2_vld_ff)
   // Every commit presents a result beat in the following cycle.
   `CTM_ASSERT_NEXT(a_commit_shows, clock, reset, cmd.commit_det || cmd.commit_eof,
      rsp_valid_ff)
   // The running total moves only at an end of frame.
   `CTM_ASSERT_NEXT(a_total_hold, clock, reset, !cmd.commit_eof, $stable(total_ff))

endmodule

// File: hw/rtl/centroid_track_matcher.sv
// Nearest-neighbour centroid tracker with upward line-crossing count; uses ctm_pkg,
// ctm_ctrl and ctm_datapath. An accepted item is latched, the live tracks are read out
// through the distance pipeline (detection) or the frame sweep (end of frame), and
// then the result register loads. One item is in flight: the next is accepted once the
// controller is idle again after the result loads; a held result beat delays the commit.
// Reset (synchronous, active high) empties the table and clears ids and total.
module centroid_track_matcher import ctm_pkg::*; #(
   parameter int MAX_TRACKS = MAX_TRACKS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   ctm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ctm_datapath #(
      .MAX_TRACKS (MAX_TRACKS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

endmodule
